// ===== src/whole_word_occurrence_counter_core_macros.svh =====
// Assertion helpers shared by the RTL files.
// Each macro expects clk and arst_n to exist in the module that uses it.
`ifndef WHOLE_WORD_OCCURRENCE_COUNTER_CORE_MACROS_SVH
`define WHOLE_WORD_OCCURRENCE_COUNTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WWOC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WWOC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/wwoc_pkg.sv =====
`default_nettype none

package wwoc_pkg;

	localparam int MAX_WORD   = 16;
	localparam int WIN_DEPTH  = MAX_WORD + 1;
	localparam int COUNT_BITS = 16;
	localparam int LEN_BITS   = 5;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [LEN_BITS-1:0] LEN_MAX = LEN_BITS'(MAX_WORD);
	localparam logic [LEN_BITS-1:0] SEEN_MAX = LEN_BITS'(WIN_DEPTH);

	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_PERIOD   = 8'h2E;
	localparam logic [7:0] CH_EXCLAIM  = 8'h21;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_HYPHEN   = 8'h2D;

	typedef enum logic [1:0] {
		REG_WORD_LENGTH = 2'd0,
		REG_CHARS_LOW   = 2'd1,
		REG_CHARS_HIGH  = 2'd2
	} cfg_reg_t;

	typedef logic [MAX_WORD-1:0][7:0] word_t;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	typedef struct packed {
		logic match_a;
		logic match_b;
		logic bound_a;
		logic bound_b;
	} cell_flags_t;

	typedef struct packed {
		logic [15:0] match_total;
		logic [1:0]  new_matches;
		logic        total_final;
	} result_t;

	function automatic logic is_delim(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_COMMA || ch == CH_PERIOD ||
			ch == CH_EXCLAIM || ch == CH_QUESTION || ch == CH_HYPHEN;
	endfunction

endpackage

`default_nettype wire

// ===== src/wwoc_channels.sv =====
`default_nettype none

interface wwoc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface wwoc_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       text_end;
	modport source(output valid, text_byte, text_end, input ready);
	modport sink(input valid, text_byte, text_end, output ready);
endinterface

interface wwoc_result_if;
	logic        valid;
	logic        ready;
	logic [15:0] match_total;
	logic [1:0]  new_matches;
	logic        total_final;
	modport source(output valid, match_total, new_matches, total_final, input ready);
	modport sink(input valid, match_total, new_matches, total_final, output ready);
endinterface

`default_nettype wire

// ===== src/whole_word_occurrence_counter_core.sv =====
// Channel | Dir | Payload                                  | Handshake
// cfg     | in  | index[1:0], data[63:0]                   | valid/ready, ready always high
// text    | in  | text_byte[7:0], text_end                 | valid/ready
// result  | out | match_total[15:0], new_matches[1:0], total_final | valid/ready
//
// A text byte is taken each cycle while the buffer has room; its result is registered.
// The window compare is combinational, over a row of 17 cells that shift the text.
// A two-word output buffer sits after the compare; input stalls only when it is full.
// Reset clears the window and counters at once; the word resets to length 1, all zero.
// A text byte with text_end set clears the window and counters for the next text.
`default_nettype none

`include "whole_word_occurrence_counter_core_macros.svh"

module whole_word_occurrence_counter_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	wwoc_cfg_if.sink       cfg,
	wwoc_text_if.sink      text,
	wwoc_result_if.source  result
);
	import wwoc_pkg::*;

	logic [LEN_BITS-1:0]   word_length_q;
	logic [63:0]           chars_low_q;
	logic [63:0]           chars_high_q;
	logic [LEN_BITS-1:0]   seen_q;
	logic [3:0]            guard_q;
	logic [COUNT_BITS-1:0] total_q;

	word_t                 word;
	logic [LEN_BITS-1:0]   eff_len;
	logic                  fire;
	logic                  room;
	cell_ctl_t             ctl;
	logic [7:0]            win [WIN_DEPTH];
	cell_flags_t           flags [WIN_DEPTH];
	logic                  all_a;
	logic                  all_b;
	logic                  bnd_a;
	logic                  bnd_b;
	logic [LEN_BITS:0]     seen_next;
	logic [LEN_BITS-1:0]   last_idx;
	logic                  ok_a;
	logic                  ok_b;
	logic                  hit_a;
	logic                  hit_b;
	logic [3:0]            guard_set;
	logic [3:0]            guard_mid;
	logic [COUNT_BITS-1:0] total_mid;
	logic [COUNT_BITS-1:0] total_new;
	logic [1:0]            found;
	result_t               res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q <= LEN_BITS'(1);
			chars_low_q   <= '0;
			chars_high_q  <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_WORD_LENGTH: word_length_q <= cfg.data[LEN_BITS-1:0];
				REG_CHARS_LOW:   chars_low_q   <= cfg.data;
				REG_CHARS_HIGH:  chars_high_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	assign word    = {chars_high_q, chars_low_q};
	assign eff_len = (word_length_q > LEN_MAX) ? LEN_MAX : word_length_q;

	assign text.ready = room;
	assign fire       = text.valid && text.ready;
	assign ctl.shift  = fire && !text.text_end;
	assign ctl.clear  = fire && text.text_end;

	for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
		logic [7:0] din;
		if (j == 0) begin : g_head
			assign din = text.text_byte;
		end else begin : g_link
			assign din = win[j-1];
		end
		wwoc_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.din   (din),
			.pos   (LEN_BITS'(j)),
			.len   (eff_len),
			.word  (word),
			.dout  (win[j]),
			.flags (flags[j])
		);
	end

	always_comb begin
		all_a = 1'b1;
		all_b = 1'b1;
		bnd_a = 1'b0;
		bnd_b = 1'b0;
		for (int j = 0; j < WIN_DEPTH; j++) begin
			all_a = all_a & flags[j].match_a;
			all_b = all_b & flags[j].match_b;
			bnd_a = bnd_a | flags[j].bound_a;
			bnd_b = bnd_b | flags[j].bound_b;
		end
	end

	assign seen_next = {1'b0, seen_q} + (LEN_BITS+1)'(1);
	assign last_idx  = eff_len - LEN_BITS'(1);
	assign guard_set = last_idx[3:0];

	always_comb begin
		ok_a = (eff_len != '0) && (seen_q >= eff_len) && is_delim(text.text_byte) &&
			((seen_q == eff_len) || bnd_a) && all_a;
		hit_a = ok_a && (guard_q == '0);
		if (hit_a) begin
			guard_mid = guard_set;
		end else if (guard_q != '0) begin
			guard_mid = guard_q - 4'd1;
		end else begin
			guard_mid = guard_q;
		end
		total_mid = (hit_a && total_q != CNT_MAX) ? total_q + COUNT_BITS'(1) : total_q;

		ok_b = text.text_end && (eff_len != '0) && (seen_next >= {1'b0, eff_len}) &&
			((seen_next == {1'b0, eff_len}) || bnd_b) && all_b &&
			(text.text_byte == word[last_idx[3:0]]);
		hit_b = ok_b && (guard_mid == '0);
		total_new = (hit_b && total_mid != CNT_MAX) ? total_mid + COUNT_BITS'(1) : total_mid;

		found = {1'b0, hit_a} + {1'b0, hit_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= '0;
			guard_q <= '0;
			total_q <= '0;
		end else if (fire) begin
			if (text.text_end) begin
				seen_q  <= '0;
				guard_q <= '0;
				total_q <= '0;
			end else begin
				seen_q  <= (seen_q < SEEN_MAX) ? seen_next[LEN_BITS-1:0] : seen_q;
				guard_q <= guard_mid;
				total_q <= total_new;
			end
		end
	end

	assign res.match_total = 16'(total_new);
	assign res.new_matches = found;
	assign res.total_final = text.text_end;

	wwoc_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.push_data(res),
		.room     (room),
		.result   (result)
	);

	`WWOC_ASSERT_NEXT(a_clear_on_end, fire && text.text_end,
		seen_q == '0 && guard_q == '0 && total_q == '0 && win[WIN_DEPTH-1] == '0,
		"text state not cleared after the final word")
	`WWOC_ASSERT_NEXT(a_guard_load, fire && !text.text_end && hit_a,
		guard_q == $past(guard_set), "overlap guard not loaded after a match")
	`WWOC_ASSERT_NOW(a_two_only_single, fire && found == 2'd2, eff_len == LEN_BITS'(1),
		"two matches confirmed for a word longer than one character")

endmodule

`default_nettype wire

// ===== src/wwoc_cell.sv =====
`default_nettype none

module wwoc_cell (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire wwoc_pkg::cell_ctl_t            ctl,
	input  wire logic [7:0]                     din,
	input  wire logic [wwoc_pkg::LEN_BITS-1:0]  pos,
	input  wire logic [wwoc_pkg::LEN_BITS-1:0]  len,
	input  wire wwoc_pkg::word_t                word,
	output logic [7:0]                          dout,
	output wwoc_pkg::cell_flags_t               flags
);
	import wwoc_pkg::*;

	logic [7:0]          win_q;
	logic [LEN_BITS-1:0] idx_a;
	logic [LEN_BITS-1:0] idx_b;
	logic [LEN_BITS:0]   pos_x;
	logic [LEN_BITS:0]   len_x;
	logic                need_b;
	logic                delim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (ctl.clear) begin
			win_q <= '0;
		end else if (ctl.shift) begin
			win_q <= din;
		end
	end

	assign dout   = win_q;
	assign idx_a  = len - pos - LEN_BITS'(1);
	assign idx_b  = len - pos - LEN_BITS'(2);
	assign pos_x  = {1'b0, pos};
	assign len_x  = {1'b0, len};
	assign need_b = (pos_x + (LEN_BITS+1)'(2)) <= len_x;
	assign delim  = is_delim(win_q);

	// Cell j holds the character j+1 places before the current one and checks it against the word
	// character it must equal for a candidate ending one character ago (a) or
	// ending on the current character (b).
	always_comb begin
		flags.match_a = (pos >= len) || (win_q == word[idx_a[3:0]]);
		flags.match_b = !need_b || (win_q == word[idx_b[3:0]]);
		flags.bound_a = (pos == len) && delim;
		flags.bound_b = ((pos_x + (LEN_BITS+1)'(1)) == len_x) && delim;
	end

endmodule

`default_nettype wire

// ===== src/wwoc_out_buf.sv =====
`default_nettype none

`include "whole_word_occurrence_counter_core_macros.svh"

module wwoc_out_buf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire wwoc_pkg::result_t push_data,
	output logic                   room,
	wwoc_result_if.source          result
);
	import wwoc_pkg::*;

	logic [1:0] cnt_q;
	result_t    data0_q;
	result_t    data1_q;
	logic       pop;

	assign pop  = result.valid && result.ready;
	assign room = cnt_q != 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_q == 2'd0) begin
			if (push) begin
				data0_q <= push_data;
			end
		end else if (cnt_q == 2'd1) begin
			if (push && pop) begin
				data0_q <= push_data;
			end else if (push) begin
				data1_q <= push_data;
			end
		end else if (pop) begin
			data0_q <= data1_q;
		end
	end

	assign result.valid       = cnt_q != 2'd0;
	assign result.match_total = data0_q.match_total;
	assign result.new_matches = data0_q.new_matches;
	assign result.total_final = data0_q.total_final;

	`WWOC_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q != 2'd3, "output buffer count out of range")
	`WWOC_ASSERT_NOW(a_no_overflow, push, cnt_q != 2'd2, "push into a full output buffer")
	`WWOC_ASSERT_NEXT(a_drain, pop && !push && cnt_q == 2'd1, cnt_q == 2'd0,
		"output buffer did not empty")

endmodule

`default_nettype wire
